/* rtl/vpd_pkg.sv */
// Shared types, codes and constants of the varint posting decoder.
package vpd_pkg;

  localparam int DELETE_WORDS_DEF = 1024;
  localparam int CMD_DEPTH        = 4;
  localparam int OUT_DEPTH        = 4;

  localparam logic [1:0]  OP_BYTE = 2'd0;
  localparam logic [1:0]  OP_END  = 2'd1;
  localparam logic [1:0]  OP_DEL  = 2'd2;

  localparam logic [2:0]  ADDR_DOC_BASE = 3'd0;
  localparam logic [2:0]  ADDR_MAX_DOC  = 3'd4;

  localparam logic [16:0] DOC_MAX_RST  = 17'h10000;
  localparam logic [16:0] ACC_MAX      = 17'h1FFFF;
  localparam logic [30:0] ID_OUT_MAX   = 31'h7FFFFFFF;
  localparam logic [2:0]  SHIFT_MAX    = 3'd7;
  localparam int          CONT_BIT     = 7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [9:0]  del_addr;
    logic [63:0] del_word;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [30:0] doc_id;
    logic [7:0]  weight_lo;
    logic [7:0]  weight_hi;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_VARINT = 2'd0,
    PH_W0     = 2'd1,
    PH_W1     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_JUDGE = 2'd0,
    CMD_END   = 2'd1,
    CMD_DEL   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [16:0] id;
    logic [7:0]  w0;
    logic [7:0]  w1;
    logic [9:0]  addr;
    logic [63:0] word;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic cmd_pop;
  } back_status_t;

endpackage

/* rtl/vpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/vpd_fifo.sv */
// Small register FIFO used between the decoder parts and at the result side.
module vpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic [CW-1:0]    count,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && (count_r != CW'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;
  assign empty = (count_r == '0);

endmodule

/* rtl/vpd_front.sv */
// Front end: varint parser that turns input transactions into back-end commands.
module vpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  vpd_pkg::in_item_t  item,
  input  logic [16:0]        max_doc,
  output logic               cmd_push,
  output vpd_pkg::cmd_t      cmd
);

  vpd_pkg::phase_t phase_r, phase_nxt;
  logic [16:0]     acc_r, acc_nxt;
  logic [2:0]      shift_r, shift_nxt;
  logic [7:0]      w0_r, w0_nxt;
  logic [16:0]     part;
  logic            ovf;
  logic [7:0]      b;

  assign b = item.data_byte;

  always_comb begin
    unique case (shift_r)
      3'd0: begin
        part = {10'd0, b[6:0]};
        ovf  = 1'b0;
      end
      3'd1: begin
        part = {3'd0, b[6:0], 7'd0};
        ovf  = 1'b0;
      end
      3'd2: begin
        part = {b[2:0], 14'd0};
        ovf  = |b[6:3];
      end
      default: begin
        part = '0;
        ovf  = |b[6:0];
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    w0_nxt    = w0_r;
    cmd_push  = 1'b0;
    cmd.kind  = vpd_pkg::CMD_END;
    cmd.id    = acc_r;
    cmd.w0    = w0_r;
    cmd.w1    = b;
    cmd.addr  = item.del_addr;
    cmd.word  = item.del_word;
    if (accept) begin
      priority if (item.opcode == vpd_pkg::OP_DEL) begin
        cmd_push = 1'b1;
        cmd.kind = vpd_pkg::CMD_DEL;
      end else if (item.opcode == vpd_pkg::OP_END) begin
        cmd_push  = 1'b1;
        cmd.kind  = vpd_pkg::CMD_END;
        phase_nxt = vpd_pkg::PH_VARINT;
        acc_nxt   = '0;
        shift_nxt = '0;
      end else if (item.opcode == vpd_pkg::OP_BYTE) begin
        unique case (phase_r)
          vpd_pkg::PH_W0: begin
            w0_nxt    = b;
            phase_nxt = vpd_pkg::PH_W1;
          end
          vpd_pkg::PH_W1: begin
            cmd_push  = 1'b1;
            cmd.kind  = (acc_r >= max_doc) ? vpd_pkg::CMD_END : vpd_pkg::CMD_JUDGE;
            phase_nxt = vpd_pkg::PH_VARINT;
            acc_nxt   = '0;
            shift_nxt = '0;
          end
          default: begin
            acc_nxt = ovf ? vpd_pkg::ACC_MAX : (acc_r | part);
            if (b[vpd_pkg::CONT_BIT]) begin
              shift_nxt = (shift_r == vpd_pkg::SHIFT_MAX) ? shift_r : shift_r + 1'b1;
              phase_nxt = vpd_pkg::PH_VARINT;
            end else begin
              shift_nxt = '0;
              phase_nxt = vpd_pkg::PH_W0;
            end
          end
        endcase
      end else begin
        cmd_push = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= vpd_pkg::PH_VARINT;
      acc_r   <= '0;
      shift_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w0_r <= w0_nxt;
  end

endmodule

/* rtl/vpd_back.sv */
// Back end: deletion bitmap, record judgment and result queue.
module vpd_back #(
  parameter int DELETE_WORDS = vpd_pkg::DELETE_WORDS_DEF,
  localparam int AW = (DELETE_WORDS > 1) ? $clog2(DELETE_WORDS) : 1,
  localparam int OCW = $clog2(vpd_pkg::OUT_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_empty,
  input  vpd_pkg::cmd_t          cmd_head,
  input  logic [30:0]            doc_base,
  input  logic                   out_pop,
  output logic                   out_empty,
  output vpd_pkg::out_item_t     out_item,
  output vpd_pkg::back_status_t  status
);

  localparam logic [16:0] WORDS17 = 17'(DELETE_WORDS);

  logic          clr_active_r, clr_active_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;

  logic          s1_valid_r;
  logic          s1_end_r;
  logic          s1_in_range_r;
  logic [5:0]    s1_bit_r;
  logic [16:0]   s1_id_r;
  logic [7:0]    s1_w0_r;
  logic [7:0]    s1_w1_r;

  logic [OCW-1:0] out_count;
  logic [OCW:0]   out_used;
  logic           issue;
  logic [16:0]    rd_word17;
  logic [16:0]    wr_word17;
  logic           rd_in_range;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [63:0]    ram_wdata;
  logic           ram_re;
  logic [63:0]    ram_rdata;

  logic           res_push;
  vpd_pkg::out_item_t res;
  logic [31:0]    sum;
  logic           deleted;
  logic [$bits(vpd_pkg::out_item_t)-1:0] out_vec;

  assign out_used = {1'b0, out_count} + {{OCW{1'b0}}, s1_valid_r};
  assign issue    = !clr_active_r && !cmd_empty && (out_used < (OCW + 1)'(vpd_pkg::OUT_DEPTH));

  assign rd_word17   = {6'd0, cmd_head.id[16:6]};
  assign wr_word17   = {7'd0, cmd_head.addr};
  assign rd_in_range = rd_word17 < WORDS17;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    ram_we         = 1'b0;
    ram_waddr      = wr_word17[AW-1:0];
    ram_wdata      = cmd_head.word;
    ram_re         = 1'b0;
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
      if (clr_idx_r == AW'(DELETE_WORDS - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
    end else if (issue) begin
      unique case (cmd_head.kind)
        vpd_pkg::CMD_DEL:   ram_we = (wr_word17 < WORDS17);
        vpd_pkg::CMD_JUDGE: ram_re = rd_in_range;
        default:            ram_re = 1'b0;
      endcase
    end
  end

  vpd_ram #(
    .WIDTH(64),
    .DEPTH(DELETE_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_word17[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
      s1_valid_r   <= issue && (cmd_head.kind != vpd_pkg::CMD_DEL);
    end
  end

  always_ff @(posedge clk) begin
    s1_end_r      <= (cmd_head.kind != vpd_pkg::CMD_JUDGE);
    s1_in_range_r <= rd_in_range;
    s1_bit_r      <= cmd_head.id[5:0];
    s1_id_r       <= cmd_head.id;
    s1_w0_r       <= cmd_head.w0;
    s1_w1_r       <= cmd_head.w1;
  end

  assign sum     = {15'd0, s1_id_r} + {1'b0, doc_base};
  assign deleted = s1_in_range_r && ram_rdata[s1_bit_r];

  always_comb begin
    res_push = 1'b0;
    res      = '0;
    if (s1_valid_r) begin
      if (s1_end_r) begin
        res_push   = 1'b1;
        res.status = 1'b1;
      end else if (!deleted) begin
        res_push      = 1'b1;
        res.status    = 1'b0;
        res.doc_id    = sum[31] ? vpd_pkg::ID_OUT_MAX : sum[30:0];
        res.weight_lo = s1_w0_r;
        res.weight_hi = s1_w1_r;
      end
    end
  end

  vpd_fifo #(
    .WIDTH($bits(vpd_pkg::out_item_t)),
    .DEPTH(vpd_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .pop   (out_pop),
    .rdata (out_vec),
    .count (out_count),
    .empty (out_empty)
  );

  assign out_item        = vpd_pkg::out_item_t'(out_vec);
  assign status.clearing = clr_active_r;
  assign status.cmd_pop  = issue;

endmodule

/* rtl/varint_posting_decoder_core.sv */
// Top level of the varint posting decoder: configuration registers and part wiring.
// Takes one transaction per clock cycle on the input queue while full is low and delivers
// one result per cycle on the output queue while it is popped; a record result goes from
// the command queue, written at the edge that accepts its last byte, through the registered
// bitmap read into the result queue and then shows on the output ports (a deleted record
// gives none). After reset full stays high while the deletion bitmap RAM is swept to zero,
// one word a cycle; configuration writes are taken during that pass.
module varint_posting_decoder_core #(
  parameter int DELETE_WORDS = vpd_pkg::DELETE_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  vpd_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output vpd_pkg::out_item_t out_item,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int CCW = $clog2(vpd_pkg::CMD_DEPTH + 1);

  logic [30:0] doc_base_r;
  logic [16:0] max_doc_r;
  logic        cfg_wr;
  logic        accept;

  logic                  cmd_push;
  vpd_pkg::cmd_t         cmd_new;
  logic [$bits(vpd_pkg::cmd_t)-1:0] cmd_vec;
  vpd_pkg::cmd_t         cmd_head;
  logic [CCW-1:0]        cmd_count;
  logic                  cmd_empty;
  vpd_pkg::back_status_t back_st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      doc_base_r <= '0;
      max_doc_r  <= vpd_pkg::DOC_MAX_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == vpd_pkg::ADDR_MAX_DOC[2]) begin
        max_doc_r <= cfg_pwdata[16:0];
      end else begin
        doc_base_r <= cfg_pwdata[30:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == vpd_pkg::ADDR_MAX_DOC[2]) ? {15'd0, max_doc_r}
                                                                 : {1'b0, doc_base_r};

  assign full   = back_st.clearing || (cmd_count == CCW'(vpd_pkg::CMD_DEPTH));
  assign accept = push && !full;

  vpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .max_doc  (max_doc_r),
    .cmd_push (cmd_push),
    .cmd      (cmd_new)
  );

  vpd_fifo #(
    .WIDTH($bits(vpd_pkg::cmd_t)),
    .DEPTH(vpd_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_new),
    .pop   (back_st.cmd_pop),
    .rdata (cmd_vec),
    .count (cmd_count),
    .empty (cmd_empty)
  );

  assign cmd_head = vpd_pkg::cmd_t'(cmd_vec);

  vpd_back #(
    .DELETE_WORDS(DELETE_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .doc_base  (doc_base_r),
    .out_pop   (pop),
    .out_empty (empty),
    .out_item  (out_item),
    .status    (back_st)
  );

endmodule
